[rtl/tgdg_pkg.sv]
// Shared types, constants, and rounding and saturation helpers for the trilinear grid block.
package tgdg_pkg;

    localparam int AXIS_MAX = 32;
    localparam int DIMS     = 3;
    localparam int CW       = $clog2(AXIS_MAX);
    localparam int AW       = 3 * CW;
    localparam int RW       = DIMS * 32;
    localparam int MA       = 34;
    localparam int MB       = 33;
    localparam int PW       = 64;
    localparam int AC       = 52;
    localparam logic [16:0] Q16_ONE = 17'd65536;

    typedef enum logic [1:0] {
        FN_DEPOSIT = 2'd0,
        FN_GATHER  = 2'd1,
        FN_CLEAR   = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_SPACING  = 3'd3,
        CFG_INV_SP   = 3'd4,
        CFG_SIZE_X   = 3'd5,
        CFG_SIZE_Y   = 3'd6,
        CFG_SIZE_Z   = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_AXD, ST_AXQ, ST_AXC, ST_AXDL, ST_AXF, ST_AXFC,
        ST_CW1, ST_CW2, ST_CW3, ST_CM, ST_CA, ST_CWB, ST_DONE
    } t_state;

    // Round a Q32 product to Q16, half away from zero.
    function automatic logic signed [PW-1:0] round_q16(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        mag = v[PW-1] ? (~v + 64'd1) : v;
        r   = (mag + 64'd32768) >> 16;
        return v[PW-1] ? $signed(~r + 64'd1) : $signed(r);
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (!v[PW-1] && (|v[PW-2:31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[PW-1] && !(&v[PW-2:31])) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/tgdg_mul.sv]
// Shared signed multiplier with a registered product.
module tgdg_mul
    import tgdg_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [MA-1:0] i_a,
    input  logic signed [MB-1:0] i_b,
    output logic signed [PW-1:0] o_p
);

    logic signed [MA+MB-1:0] w_full;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        o_p <= w_full[PW-1:0];
    end

endmodule

[rtl/tgdg_ram.sv]
// Grid store: one row per grid point holding every vector component.
module tgdg_ram
    import tgdg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [RW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [RW-1:0] o_rdata
);

    logic [RW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/trilinear_grid_deposit_gather.sv]
// Top level: trilinear cloud-in-cell deposit, gather and clear over a 3D grid.
//
// Channel  Direction  Contents
// s_axis   in         tdata: pos_x, pos_y, pos_z, weight_0..2; tuser: func
// m_axis   out        tdata: value_0..2; tuser: out_of_range
// cfg      in         write enable, register index, write data
//
// A deposit or gather runs three axes of six steps each, then ten steps for each
// of the eight corners, all sharing one multiplier; an out-of-range axis ends it early.
// A clear transaction and the pass after reset walk all 32768 rows of the grid
// memory one row a cycle; no input transaction is taken meanwhile.
// A finished result sits in the output register while the next transaction
// is accepted; a stalled output only blocks the end of the following item.
module trilinear_grid_deposit_gather
    import tgdg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // pos_x, pos_y, pos_z, weight_0, weight_1, weight_2
    input  logic [1:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // value_0, value_1, value_2
    output logic [0:0]   m_axis_tuser,   // out_of_range
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    // Configuration registers.
    logic signed [31:0] r_org [3];
    logic [30:0]        r_spacing;
    logic [30:0]        r_inv;
    logic [5:0]         r_size [3];

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    t_func              r_func, n_func;
    logic signed [31:0] r_pos [3], n_pos [3];
    logic signed [31:0] r_wt [DIMS], n_wt [DIMS];
    logic [1:0]         r_axis, n_axis;
    logic signed [32:0] r_d, n_d;
    logic [CW-1:0]      r_cell [3], n_cell [3];
    logic [16:0]        r_frac [3], n_frac [3];
    logic [30:0]        r_dl, n_dl;
    logic [2:0]         r_k, n_k;
    logic [1:0]         r_i, n_i;
    logic [16:0]        r_rho, n_rho;
    logic signed [31:0] r_new [DIMS], n_new [DIMS];
    logic signed [AC-1:0] r_acc [DIMS], n_acc [DIMS];
    logic               r_oor, n_oor;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_item, n_item;
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_oval [DIMS], n_oval [DIMS];
    logic               r_ooor, n_ooor;

    // Shared multiplier and memory connections.
    logic signed [MA-1:0] m_a;
    logic signed [MB-1:0] m_b;
    logic signed [PW-1:0] m_p;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [RW-1:0]        ram_wdata, ram_rdata;

    // Helper values.
    logic [CW-1:0]        w_cx, w_cy, w_cz;
    logic [AW-1:0]        w_corner;
    logic [16:0]          w_wx, w_wy, w_wz;
    logic [6:0]           w_lim;
    logic                 w_bad;
    logic signed [37:0]   w_dl;
    logic signed [31:0]   w_rd;
    logic                 w_out_free;

    tgdg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (m_a),
        .i_b   (m_b),
        .o_p   (m_p)
    );

    tgdg_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Corner k picks the low or high neighbor along each axis by its bits.
    assign w_cx     = r_cell[0] + CW'(r_k[0]);
    assign w_cy     = r_cell[1] + CW'(r_k[1]);
    assign w_cz     = r_cell[2] + CW'(r_k[2]);
    assign w_corner = {w_cz, w_cy, w_cx};
    assign w_wx     = r_k[0] ? r_frac[0] : (Q16_ONE - r_frac[0]);
    assign w_wy     = r_k[1] ? r_frac[1] : (Q16_ONE - r_frac[1]);
    assign w_wz     = r_k[2] ? r_frac[2] : (Q16_ONE - r_frac[2]);

    // Usable grid points along the current axis; the last cell starts at lim - 2.
    assign w_lim = ({1'b0, r_size[r_axis]} > 7'(AXIS_MAX)) ? 7'(AXIS_MAX)
                                                          : {1'b0, r_size[r_axis]};
    assign w_bad = m_p[PW-1] || (w_lim < 7'd2) ||
                   (m_p[62:32] > {24'd0, w_lim - 7'd2});

    // Offset of the point inside its cell before clamping.
    assign w_dl = $signed({{5{r_d[32]}}, r_d}) - $signed(m_p[37:0]);

    assign w_rd = ram_rdata[32*r_i +: 32];
    assign w_out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ooor;

    always_comb begin
        m_axis_tdata = '0;
        for (int j = 0; j < DIMS; j++) begin
            m_axis_tdata[32*j +: 32] = r_oval[j];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (&r_clr) begin
                    n_state = r_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (t_func'(s_axis_tuser))
                        FN_CLEAR:              n_state = ST_CLR;
                        FN_NOP:                n_state = ST_DONE;
                        FN_DEPOSIT, FN_GATHER: n_state = ST_AXD;
                    endcase
                end
            end
            ST_AXD:  n_state = ST_AXQ;
            ST_AXQ:  n_state = ST_AXC;
            ST_AXC:  n_state = w_bad ? ST_DONE : ST_AXDL;
            ST_AXDL: n_state = ST_AXF;
            ST_AXF:  n_state = ST_AXFC;
            ST_AXFC: n_state = (r_axis == 2'd2) ? ST_CW1 : ST_AXD;
            ST_CW1:  n_state = ST_CW2;
            ST_CW2:  n_state = ST_CW3;
            ST_CW3:  n_state = ST_CM;
            ST_CM:   n_state = ST_CA;
            ST_CA:   n_state = (r_i == 2'(DIMS - 1)) ? ST_CWB : ST_CM;
            ST_CWB:  n_state = (r_k == 3'd7) ? ST_DONE : ST_CW1;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, multiplier operands and memory controls for each step.
    always_comb begin
        n_func   = r_func;
        n_pos    = r_pos;
        n_wt     = r_wt;
        n_axis   = r_axis;
        n_d      = r_d;
        n_cell   = r_cell;
        n_frac   = r_frac;
        n_dl     = r_dl;
        n_k      = r_k;
        n_i      = r_i;
        n_rho    = r_rho;
        n_new    = r_new;
        n_acc    = r_acc;
        n_oor    = r_oor;
        n_clr    = r_clr;
        n_item   = r_item;
        n_oval   = r_oval;
        n_ooor   = r_ooor;
        n_ovalid = (r_ovalid && m_axis_tready) ? 1'b0 : r_ovalid;
        m_a       = '0;
        m_b       = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = w_corner;
        ram_raddr = w_corner;
        ram_wdata = '0;
        for (int j = 0; j < DIMS; j++) begin
            ram_wdata[32*j +: 32] = r_new[j];
        end

        unique case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func   = t_func'(s_axis_tuser);
                    n_pos[0] = s_axis_tdata[31:0];
                    n_pos[1] = s_axis_tdata[63:32];
                    n_pos[2] = s_axis_tdata[95:64];
                    for (int j = 0; j < DIMS; j++) begin
                        n_wt[j]  = s_axis_tdata[96 + 32*j +: 32];
                        n_acc[j] = '0;
                    end
                    n_axis = 2'd0;
                    n_k    = 3'd0;
                    n_oor  = 1'b0;
                    n_clr  = '0;
                    n_item = 1'b1;
                end
            end
            ST_AXD: begin
                n_d = $signed({r_pos[r_axis][31], r_pos[r_axis]}) -
                      $signed({r_org[r_axis][31], r_org[r_axis]});
            end
            ST_AXQ: begin
                m_a = $signed({r_d[32], r_d});
                m_b = $signed({2'b00, r_inv});
            end
            ST_AXC: begin
                // The product is the cell position in Q32.
                if (w_bad) begin
                    n_oor = 1'b1;
                end
                n_cell[r_axis] = m_p[32 +: CW];
                m_a = $signed(MA'(m_p[32 +: CW]));
                m_b = $signed({2'b00, r_spacing});
            end
            ST_AXDL: begin
                if (w_dl[37]) begin
                    n_dl = '0;
                end else if (w_dl > $signed({7'd0, r_spacing})) begin
                    n_dl = r_spacing;
                end else begin
                    n_dl = w_dl[30:0];
                end
            end
            ST_AXF: begin
                m_a = $signed({3'b000, r_dl});
                m_b = $signed({2'b00, r_inv});
            end
            ST_AXFC: begin
                n_frac[r_axis] = (m_p[PW-1:16] > 48'd65536) ? Q16_ONE : m_p[32:16];
                n_axis = r_axis + 2'd1;
            end
            ST_CW1: begin
                m_a = $signed(MA'(w_wx));
                m_b = $signed(MB'(w_wy));
            end
            ST_CW2: begin
                m_a = $signed({1'b0, m_p[32:0]});
                m_b = $signed(MB'(w_wz));
                ram_re = 1'b1;
            end
            ST_CW3: begin
                n_rho = 17'(({1'b0, m_p[48:0]} + 50'd2147483648) >> 32);
                n_i   = 2'd0;
            end
            ST_CM: begin
                m_a = (r_func == FN_DEPOSIT) ? $signed({{2{r_wt[r_i][31]}}, r_wt[r_i]})
                                             : $signed({{2{w_rd[31]}}, w_rd});
                m_b = $signed(MB'(r_rho));
            end
            ST_CA: begin
                if (r_func == FN_DEPOSIT) begin
                    n_new[r_i] = sat32($signed({{32{w_rd[31]}}, w_rd}) + round_q16(m_p));
                end else begin
                    n_acc[r_i] = r_acc[r_i] + $signed(m_p[AC-1:0]);
                end
                n_i = r_i + 2'd1;
            end
            ST_CWB: begin
                ram_we = (r_func == FN_DEPOSIT);
                n_k    = r_k + 3'd1;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    for (int j = 0; j < DIMS; j++) begin
                        n_oval[j] = (r_func == FN_GATHER && !r_oor)
                                  ? sat32(round_q16($signed({{(PW-AC){r_acc[j][AC-1]}},
                                                             r_acc[j]})))
                                  : 32'sd0;
                    end
                    n_ooor   = r_oor;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_item   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_item   <= n_item;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_pos  <= n_pos;
        r_wt   <= n_wt;
        r_axis <= n_axis;
        r_d    <= n_d;
        r_cell <= n_cell;
        r_frac <= n_frac;
        r_dl   <= n_dl;
        r_k    <= n_k;
        r_i    <= n_i;
        r_rho  <= n_rho;
        r_new  <= n_new;
        r_acc  <= n_acc;
        r_oor  <= n_oor;
        r_oval <= n_oval;
        r_ooor <= n_ooor;
    end

    // Configuration writes land at once; the user must write only while the block is idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_spacing <= 31'd65536;
            r_inv     <= 31'd65536;
            r_size[0] <= 6'd32;
            r_size[1] <= 6'd32;
            r_size[2] <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_ORIGIN_X: r_org[0]  <= i_cfg_wdata;
                CFG_ORIGIN_Y: r_org[1]  <= i_cfg_wdata;
                CFG_ORIGIN_Z: r_org[2]  <= i_cfg_wdata;
                CFG_SPACING:  r_spacing <= i_cfg_wdata[30:0];
                CFG_INV_SP:   r_inv     <= i_cfg_wdata[30:0];
                CFG_SIZE_X:   r_size[0] <= i_cfg_wdata[5:0];
                CFG_SIZE_Y:   r_size[1] <= i_cfg_wdata[5:0];
                CFG_SIZE_Z:   r_size[2] <= i_cfg_wdata[5:0];
            endcase
        end
    end

endmodule
